// ===== rtl/cbz_pkg.sv =====
// Shared types and constants for the cubic Bezier curve generator.
// Used by every module of the block; depends on nothing else.
package cbz_pkg;

  // Coordinate and curve resolution.
  localparam int COORD_BITS   = 10;
  localparam int SEG_W        = 3;
  localparam int MAX_SEG_LOG2 = 5;

  // Curve index k runs 0..N with N at most 2^MAX_SEG_LOG2.
  localparam int K_W    = MAX_SEG_LOG2 + 1;
  // Squares and cross products of k and N-k.
  localparam int SQ_W   = 2 * MAX_SEG_LOG2 + 1;
  // Bernstein weights scaled by N^3, each at most 2^(3*MAX_SEG_LOG2).
  localparam int W_W    = 3 * MAX_SEG_LOG2 + 1;
  localparam int PROD_W = W_W + COORD_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SH_W   = 4;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [SEG_W-1:0]      SEG_RESET    = SEG_W'(5);
  localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(600);

  // Depth of the curve job queue between front and back.
  localparam int JQ_DEPTH = 2;

  // Register indexes, taken from paddr[2].
  typedef enum logic {
    REG_SEGMENTS = 1'b0,
    REG_HEIGHT   = 1'b1
  } reg_idx_t;

  // Back-end sequencer states.
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  // One curve to evaluate: four control points and the clamped segment count.
  typedef struct packed {
    logic [SEG_W-1:0] s;
    point_t [3:0]     pts;
  } job_t;

endpackage

// ===== rtl/cbz_front.sv =====
// Front end: configuration registers and control point collection.
// Depends on cbz_pkg; hands finished curve jobs to cbz_jobq.
module cbz_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbz_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cbz_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cbz_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_press,
  input  logic [cbz_pkg::COORD_BITS-1:0]   in_click_x,
  input  logic [cbz_pkg::COORD_BITS-1:0]   in_click_y,
  input  logic                             jq_full,
  output logic                             jq_push,
  output cbz_pkg::job_t                    jq_job
);
  import cbz_pkg::*;

  logic [SEG_W-1:0]      seg_r, seg_nxt;
  logic [COORD_BITS-1:0] height_r, height_nxt;
  logic [1:0]            held_r, held_nxt;
  point_t                cp_r [0:2];
  point_t                pt_new;
  logic                  cfg_wr;
  reg_idx_t              reg_idx;
  logic                  take;
  logic [SEG_W-1:0]      seg_clamped;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    seg_nxt    = seg_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_SEGMENTS: seg_nxt    = pwdata[SEG_W-1:0];
        REG_HEIGHT:   height_nxt = pwdata[COORD_BITS-1:0];
        default:      seg_nxt    = seg_r;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    case (reg_idx)
      REG_SEGMENTS: prdata = {{(CFG_DATA_W-SEG_W){1'b0}}, seg_r};
      REG_HEIGHT:   prdata = {{(CFG_DATA_W-COORD_BITS){1'b0}}, height_r};
      default:      prdata = '0;
    endcase
  end

  // A beat is taken whenever the job queue has room for a finished curve.
  assign full = jq_full;
  assign take = push && !full && in_press;

  // Flip y to bottom-up, saturating at zero.
  always_comb begin
    pt_new.x = in_click_x;
    pt_new.y = (height_r > in_click_y) ? (height_r - in_click_y) : '0;
  end

  assign held_nxt    = take ? (held_r + 2'd1) : held_r;
  assign seg_clamped = (seg_r > SEG_W'(MAX_SEG_LOG2)) ? SEG_W'(MAX_SEG_LOG2) : seg_r;

  // The fourth press completes a job.
  always_comb begin
    jq_push    = take && (held_r == 2'd3);
    jq_job.s   = seg_clamped;
    jq_job.pts = {pt_new, cp_r[2], cp_r[1], cp_r[0]};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r    <= SEG_RESET;
      height_r <= HEIGHT_RESET;
      held_r   <= 2'd0;
    end else begin
      seg_r    <= seg_nxt;
      height_r <= height_nxt;
      held_r   <= held_nxt;
    end
  end

  // Control point store for the first three presses.
  always_ff @(posedge clk) begin
    if (take && (held_r != 2'd3)) begin
      cp_r[held_r] <= pt_new;
    end
  end

endmodule

// ===== rtl/cbz_jobq.sv =====
// Short queue of curve jobs between the front and back ends.
// Depends on cbz_pkg for the job type.
module cbz_jobq #(
  parameter int Depth = cbz_pkg::JQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cbz_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output cbz_pkg::job_t pop_job,
  output logic          empty
);
  import cbz_pkg::*;

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  job_t             mem_r [0:Depth-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  // Pointer and count updates with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/cbz_back.sv =====
// Back end: steps k over one curve and evaluates the Bernstein form in a
// four-stage pipeline ending in the result register. Depends on cbz_pkg.
module cbz_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           jq_empty,
  input  cbz_pkg::job_t                  jq_job,
  output logic                           jq_pop,
  input  logic                           pop,
  output logic                           empty,
  output logic [cbz_pkg::COORD_BITS-1:0] out_curve_x,
  output logic [cbz_pkg::COORD_BITS-1:0] out_curve_y,
  output logic                           out_last_point
);
  import cbz_pkg::*;

  localparam int M_W = SQ_W + K_W;

  typedef struct packed {
    logic             last;
    logic [SEG_W-1:0] s;
    point_t [3:0]     pts;
    logic [K_W-1:0]   tk;
    logic [K_W-1:0]   uk;
    logic [SQ_W-1:0]  tt;
    logic [SQ_W-1:0]  uu;
    logic [SQ_W-1:0]  tu;
  } s1_t;

  typedef struct packed {
    logic                  last;
    logic [SEG_W-1:0]      s;
    point_t [3:0]          pts;
    logic [3:0][W_W-1:0]   w;
  } s2_t;

  typedef struct packed {
    logic                   last;
    logic [SEG_W-1:0]       s;
    logic [3:0][PROD_W-1:0] px;
    logic [3:0][PROD_W-1:0] py;
  } s3_t;

  seq_state_t            state_r, state_nxt;
  job_t                  job_r;
  logic [K_W-1:0]        k_r, k_nxt;
  logic [K_W-1:0]        n_w;
  logic                  issue;
  logic                  adv;

  s1_t                   s1_r, s1_nxt;
  s2_t                   s2_r, s2_nxt;
  s3_t                   s3_r, s3_nxt;
  logic                  s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic [COORD_BITS-1:0] curve_x_r, curve_x_nxt;
  logic [COORD_BITS-1:0] curve_y_r, curve_y_nxt;
  logic                  last_r;

  logic [M_W-1:0]        m_uuu, m_tuu, m_tut, m_ttt;
  logic [M_W:0]          m_tuu3, m_tut3;
  logic [ACC_W-1:0]      acc_x, acc_y, sh_x, sh_y;
  logic [SH_W-1:0]       sh;

  // The whole pipeline moves unless a result is held in the output register and not popped.
  assign adv   = !out_v_r || pop;
  assign empty = !out_v_r;
  assign n_w   = {{(K_W-1){1'b0}}, 1'b1} << job_r.s;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: if (!jq_empty) state_nxt = SEQ_RUN;
      SEQ_RUN:  if (adv && (k_r == n_w)) state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    jq_pop = 1'b0;
    issue  = 1'b0;
    case (state_r)
      SEQ_IDLE: jq_pop = !jq_empty;
      SEQ_RUN:  issue  = adv;
      default:  jq_pop = 1'b0;
    endcase
  end

  always_comb begin
    k_nxt = k_r;
    if (jq_pop) begin
      k_nxt = '0;
    end else if (issue) begin
      k_nxt = k_r + 1'b1;
    end
  end

  // Stage 1: t and 1-t scaled by N, their squares and cross product.
  always_comb begin
    s1_nxt.last = (k_r == n_w);
    s1_nxt.s    = job_r.s;
    s1_nxt.pts  = job_r.pts;
    s1_nxt.tk   = k_r;
    s1_nxt.uk   = n_w - k_r;
    s1_nxt.tt   = SQ_W'(k_r) * SQ_W'(k_r);
    s1_nxt.uu   = SQ_W'(s1_nxt.uk) * SQ_W'(s1_nxt.uk);
    s1_nxt.tu   = SQ_W'(k_r) * SQ_W'(s1_nxt.uk);
  end

  // Stage 2: the four Bernstein weights scaled by N^3.
  assign m_uuu  = s1_r.uu * s1_r.uk;
  assign m_tuu  = s1_r.tu * s1_r.uk;
  assign m_tut  = s1_r.tu * s1_r.tk;
  assign m_ttt  = s1_r.tt * s1_r.tk;
  assign m_tuu3 = {m_tuu, 1'b0} + {1'b0, m_tuu};
  assign m_tut3 = {m_tut, 1'b0} + {1'b0, m_tut};

  always_comb begin
    s2_nxt.last = s1_r.last;
    s2_nxt.s    = s1_r.s;
    s2_nxt.pts  = s1_r.pts;
    s2_nxt.w[0] = m_uuu[W_W-1:0];
    s2_nxt.w[1] = m_tuu3[W_W-1:0];
    s2_nxt.w[2] = m_tut3[W_W-1:0];
    s2_nxt.w[3] = m_ttt[W_W-1:0];
  end

  // Stage 3: weight each control point coordinate.
  always_comb begin
    s3_nxt.last = s2_r.last;
    s3_nxt.s    = s2_r.s;
    for (int i = 0; i < 4; i++) begin
      s3_nxt.px[i] = s2_r.w[i] * s2_r.pts[i].x;
      s3_nxt.py[i] = s2_r.w[i] * s2_r.pts[i].y;
    end
  end

  // Stage 4: sum, divide by N^3 and floor.
  assign acc_x = {2'b00, s3_r.px[0]} + {2'b00, s3_r.px[1]}
               + {2'b00, s3_r.px[2]} + {2'b00, s3_r.px[3]};
  assign acc_y = {2'b00, s3_r.py[0]} + {2'b00, s3_r.py[1]}
               + {2'b00, s3_r.py[2]} + {2'b00, s3_r.py[3]};
  assign sh    = {s3_r.s, 1'b0} + {1'b0, s3_r.s};
  assign sh_x  = acc_x >> sh;
  assign sh_y  = acc_y >> sh;
  assign curve_x_nxt = sh_x[COORD_BITS-1:0];
  assign curve_y_nxt = sh_y[COORD_BITS-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      k_r     <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (adv) begin
        s1_v_r  <= issue;
        s2_v_r  <= s1_v_r;
        s3_v_r  <= s2_v_r;
        out_v_r <= s3_v_r;
      end
    end
  end

  // Job and pipeline payload.
  always_ff @(posedge clk) begin
    if (jq_pop) begin
      job_r <= jq_job;
    end
    if (adv) begin
      s1_r      <= s1_nxt;
      s2_r      <= s2_nxt;
      s3_r      <= s3_nxt;
      curve_x_r <= curve_x_nxt;
      curve_y_r <= curve_y_nxt;
      last_r    <= s3_r.last;
    end
  end

  assign out_curve_x    = curve_x_r;
  assign out_curve_y    = curve_y_r;
  assign out_last_point = last_r;

endmodule

// ===== rtl/cubic_bezier_curve_generator_unit.sv =====
// Top level of the cubic Bezier curve generator.
// Instantiates cbz_front, cbz_jobq and cbz_back; depends on cbz_pkg.
//
// Usage:
//   Input queue: push with in_press, in_click_x and in_click_y; a beat is
//   taken when push is high and full is low. Release beats are dropped.
//   Every fourth press completes a curve; its y values are flipped against
//   window_height and saturated at zero.
//   Result queue: while empty is low, out_curve_x, out_curve_y and
//   out_last_point show the oldest point; pop takes it. A curve gives
//   2^segments_log2 + 1 points with segments_log2 clamped to 5, the last one marked.
//   Configuration: APB-style port, segments_log2 at byte 0 and
//   window_height at byte 4; write only while the block is idle.
//   Timing: a completed job passes through the job queue; the back-end
//   sequencer loads it and issues its points into the evaluation pipeline.
//   Points leave one per cycle while the receiver pops, with a job load between curves.
//   The job queue holds JobqDepth curves; full rises only when it is full.
//   When the receiver stalls, the evaluation pipeline freezes in place and
//   the front keeps taking presses until the job queue fills.
//   Reset clears the point count, the queues and restores the registers.
module cubic_bezier_curve_generator_unit #(
  parameter int JobqDepth = cbz_pkg::JQ_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbz_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbz_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbz_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           push,
  output logic                           full,
  input  logic                           in_press,
  input  logic [cbz_pkg::COORD_BITS-1:0] in_click_x,
  input  logic [cbz_pkg::COORD_BITS-1:0] in_click_y,
  output logic                           empty,
  input  logic                           pop,
  output logic [cbz_pkg::COORD_BITS-1:0] out_curve_x,
  output logic [cbz_pkg::COORD_BITS-1:0] out_curve_y,
  output logic                           out_last_point
);
  import cbz_pkg::*;

  logic jq_full, jq_push, jq_empty, jq_pop;
  job_t jq_in_job, jq_out_job;

  // Collection and configuration.
  cbz_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .in_press   (in_press),
    .in_click_x (in_click_x),
    .in_click_y (in_click_y),
    .jq_full    (jq_full),
    .jq_push    (jq_push),
    .jq_job     (jq_in_job)
  );

  // Curve jobs waiting for evaluation.
  cbz_jobq #(
    .Depth (JobqDepth)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (jq_in_job),
    .full     (jq_full),
    .pop      (jq_pop),
    .pop_job  (jq_out_job),
    .empty    (jq_empty)
  );

  // Curve evaluation.
  cbz_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .jq_empty       (jq_empty),
    .jq_job         (jq_out_job),
    .jq_pop         (jq_pop),
    .pop            (pop),
    .empty          (empty),
    .out_curve_x    (out_curve_x),
    .out_curve_y    (out_curve_y),
    .out_last_point (out_last_point)
  );

endmodule

// ===== dv/tb_cubic_bezier_curve_generator_unit.sv =====
// Self-checking testbench for cubic_bezier_curve_generator_unit: click beats in, curve points out.
// Depends on cbz_pkg and the RTL of the unit; predicts every curve point in SystemVerilog.
module tb_cubic_bezier_curve_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cbz_pkg::*;

  localparam int CW         = COORD_BITS;
  localparam int ITEMS      = 480;
  localparam int CYCLE_CAP  = 300000;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_WAIT  = 12;
  localparam int PRINT_CAP  = 100;
  localparam logic [CW-1:0] CMAX = '1;

  typedef struct packed {
    logic          press;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } click_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
  } curve_pt_t;

  // Clock, reset and block inputs, all known from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic in_press = 1'b0;
  logic [CW-1:0] in_click_x = '0;
  logic [CW-1:0] in_click_y = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CW-1:0] out_curve_x;
  logic [CW-1:0] out_curve_y;
  logic out_last_point;

  cubic_bezier_curve_generator_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .in_press      (in_press),
    .in_click_x    (in_click_x),
    .in_click_y    (in_click_y),
    .empty         (empty),
    .pop           (pop),
    .out_curve_x   (out_curve_x),
    .out_curve_y   (out_curve_y),
    .out_last_point(out_last_point)
  );

  always #5 clk = ~clk;

  // Pending click beats and predicted curve points.
  click_t    click_q[$];
  curve_pt_t curve_pts_q[$];
  int        err_cnt = 0;
  int        press_cnt = 0;
  int        cyc_cnt = 0;
  logic      quiet = 1'b0;
  logic      hold_req = 1'b0;

  // Predictor state: settings and the control points collected so far.
  logic [SEG_W-1:0] seg_cfg = SEG_RESET;
  logic [CW-1:0]    height_cfg = HEIGHT_RESET;
  point_t           held_pts[4];
  logic [1:0]       held_cnt = '0;

  // Bernstein blend with weights scaled by N^3, then floored by the shift.
  function automatic logic [CW-1:0] bern_mix(input int unsigned p0, p1, p2, p3,
                                             input int unsigned tk, uk, s);
    longint unsigned a, b, acc;
    a = tk;
    b = uk;
    acc = b * b * b * p0 + 3 * a * b * b * p1 + 3 * a * a * b * p2 + a * a * a * p3;
    return CW'(acc >> (3 * s));
  endfunction

  // Store a pressed point; the fourth one yields the whole curve.
  task automatic predict_click(input click_t c);
    logic [CW-1:0] fy;
    int unsigned   s, n;
    curve_pt_t     pt;
    if (!c.press) return;
    fy = (height_cfg > c.y) ? height_cfg - c.y : '0;
    held_pts[held_cnt] = '{x: c.x, y: fy};
    if (held_cnt != 2'd3) begin
      held_cnt++;
      return;
    end
    held_cnt = '0;
    s = (seg_cfg > MAX_SEG_LOG2) ? MAX_SEG_LOG2 : seg_cfg;
    n = 1 << s;
    for (int unsigned k = 0; k <= n; k++) begin
      pt.x = bern_mix(held_pts[0].x, held_pts[1].x, held_pts[2].x, held_pts[3].x, k, n - k, s);
      pt.y = bern_mix(held_pts[0].y, held_pts[1].y, held_pts[2].y, held_pts[3].y, k, n - k, s);
      pt.last = (k == n);
      curve_pts_q.push_back(pt);
    end
  endtask

  // Driver: offers queued click beats with random idle bursts.
  always @(posedge clk) begin : click_driver
    click_t nxt;
    int     send_gap;
    if (!rst_n) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) predict_click('{in_press, in_click_x, in_click_y});
      if (push && full) begin
        // Keep the stalled beat on the ports.
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (click_q.size() == 0) begin
        push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 3);
        push <= 1'b0;
      end else begin
        nxt = click_q.pop_front();
        push <= 1'b1;
        in_press <= nxt.press;
        in_click_x <= nxt.x;
        in_click_y <= nxt.y;
      end
    end
  end

  // Monitor: pops curve points, checks them, and stalls at random.
  always @(posedge clk) begin : curve_monitor
    curve_pt_t want;
    int        pop_gap;
    int        hold_left;
    logic      hold_done;
    if (!rst_n) begin
      pop <= 1'b0;
      pop_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (curve_pts_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= PRINT_CAP)
            $display("%0t: unexpected curve point x=%0d y=%0d last=%0b", $time,
                     out_curve_x, out_curve_y, out_last_point);
        end else begin
          want = curve_pts_q.pop_front();
          if (out_curve_x !== want.x || out_curve_y !== want.y ||
              out_last_point !== want.last) begin
            err_cnt++;
            if (err_cnt <= PRINT_CAP)
              $display("%0t: curve point mismatch, expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       $time, want.x, want.y, want.last,
                       out_curve_x, out_curve_y, out_last_point);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // One long stall so that the job queue fills and full rises.
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        pop <= 1'b0;
      end else if (quiet) begin
        pop <= 1'b1;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        pop_gap = $urandom_range(0, 3);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // APB write: setup beat, then access beat until pready.
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SEGMENTS: seg_cfg = val[SEG_W-1:0];
      REG_HEIGHT:   height_cfg = val[CW-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic add_click(input logic press, input logic [CW-1:0] x, input logic [CW-1:0] y);
    click_q.push_back('{press, x, y});
    if (press) press_cnt++;
  endtask

  // Coordinates lean on the extremes and on the current window height.
  function automatic logic [CW-1:0] pick_coord(input logic near_height);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CMAX;
      2: return near_height ? height_cfg : CW'(1);
      3: return near_height ? CW'(height_cfg + 1) : CW'(512);
      default: return CW'($urandom);
    endcase
  endfunction

  // Four presses with release beats mixed in as noise.
  task automatic add_curve();
    for (int i = 0; i < 4; i++) begin
      while ($urandom_range(0, 7) == 0) add_click(1'b0, CW'($urandom), CW'($urandom));
      add_click(1'b1, pick_coord(1'b0), pick_coord(1'b1));
    end
  endtask

  // Wait until every beat is taken and every point has come out.
  task automatic settle();
    do @(negedge clk); while (click_q.size() != 0 || push || curve_pts_q.size() != 0);
    repeat (TAIL_WAIT) @(negedge clk);
  endtask

  // Stimulus: directed curves first, then random phases of settings.
  initial begin
    int unsigned      ncurves;
    int               phase;
    logic [SEG_W-1:0] seg_val;
    logic [CW-1:0]    h_val;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: extremes, y on and above the height, releases between.
    add_click(1'b0, CMAX, CMAX);
    add_click(1'b1, '0, '0);
    add_click(1'b1, CMAX, CMAX);
    add_click(1'b0, '0, '0);
    add_click(1'b1, CMAX, CW'(600));
    add_click(1'b1, '0, CW'(599));
    add_click(1'b1, CW'(512), CW'(1));
    add_click(1'b1, CW'(1), CMAX);
    add_click(1'b1, CMAX, '0);
    add_click(1'b1, '0, CMAX);
    settle();

    // A single segment with the tallest window.
    cfg_write(REG_SEGMENTS, 0);
    cfg_write(REG_HEIGHT, CFG_DATA_W'(CMAX));
    add_click(1'b1, CMAX, '0);
    add_click(1'b1, CMAX, '0);
    add_click(1'b1, '0, CMAX);
    add_click(1'b1, CMAX, CMAX);
    settle();

    // Segment count above the limit, and the shortest window.
    cfg_write(REG_SEGMENTS, 7);
    cfg_write(REG_HEIGHT, 1);
    add_click(1'b1, CMAX, '0);
    add_click(1'b1, '0, CW'(1));
    add_click(1'b1, CMAX, CW'(2));
    add_click(1'b1, CW'(341), CMAX);
    settle();

    phase = 0;
    while (press_cnt < ITEMS) begin
      seg_val = (phase == 2) ? SEG_W'(MAX_SEG_LOG2) : SEG_W'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: h_val = CW'(1);
        1: h_val = CMAX;
        default: h_val = CW'($urandom_range(1, 1023));
      endcase
      cfg_write(REG_SEGMENTS, CFG_DATA_W'(seg_val));
      cfg_write(REG_HEIGHT, CFG_DATA_W'(h_val));
      quiet = (press_cnt > ITEMS * 4 / 5);
      if (phase == 2) begin
        hold_req = 1'b1;
        ncurves = 10;
      end else begin
        ncurves = $urandom_range(1, 6);
      end
      for (int c = 0; c < ncurves; c++) add_curve();
      settle();
      phase++;
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
